### src/tmr0i_pkg.sv
// Shared types and constants for the Timer0 and interrupt unit.
// Used by every module of the block; depends on nothing.
`default_nettype none

package tmr0i_pkg;

  // Program counter width, fixed by the payload layout.
  localparam int PC_BITS = 13;

  // Configuration port layout.
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 8;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OPTION  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ENABLES = 2'd1;

  // Register reset values.
  localparam logic [7:0] OPTION_RESET  = 8'hFF;
  localparam logic [2:0] ENABLES_RESET = 3'd0;

  // Flag bit positions: GIE, T0IF, INTF, RBIF.
  localparam int FLAG_GIE  = 3;
  localparam int FLAG_T0IF = 2;
  localparam int FLAG_INTF = 1;
  localparam int FLAG_RBIF = 0;

  // Interrupt cause codes.
  localparam logic [1:0] CAUSE_NONE  = 2'd0;
  localparam logic [1:0] CAUSE_RB0   = 2'd1;
  localparam logic [1:0] CAUSE_RBCHG = 2'd2;
  localparam logic [1:0] CAUSE_TMR0  = 2'd3;

  localparam logic [7:0] TMR0_MAX = 8'hFF;

  // One executed instruction.
  typedef struct packed {
    logic [1:0]         cycles_passed;
    logic [7:0]         port_b;
    logic               ra4_pin;
    logic [PC_BITS-1:0] program_counter;
    logic               flag_write_enable;
    logic [3:0]         flag_write_value;
    logic               timer_write_enable;
    logic [7:0]         timer_write_value;
  } in_t;

  // One result word.
  typedef struct packed {
    logic               take_interrupt;
    logic [1:0]         interrupt_cause;
    logic [PC_BITS-1:0] return_address;
    logic [7:0]         timer_value;
    logic [3:0]         flag_bits;
  } out_t;

  // Decoded configuration handed from the register file to the core.
  typedef struct packed {
    logic       intedg;
    logic       t0cs;
    logic       t0se;
    logic       psa;
    logic [2:0] ps;
    logic       t0ie;
    logic       inte;
    logic       rbie;
  } cfg_t;

endpackage

`default_nettype wire

### src/timer0_and_interrupt_unit.sv
// Top level of the Timer0 and interrupt unit: input register, step core, result register.
// Depends on tmr0i_pkg, tmr0i_cfg and tmr0i_core.
//
// Usage:
//   The input channel (in_valid, in_stall, in_data) takes one word per
//   executed instruction. A word is accepted at a clock edge with in_valid
//   high and in_stall low. The output channel (out_valid, out_stall,
//   out_data) returns exactly one result word per input word, in order.
//   The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
//   writes OPTION (index 0) or the source enables (index 1); cfg_ready is
//   always high and writes are expected only while the unit is idle.
//   The accepting edge loads the input register; from there the word moves
//   through the interrupt and Timer0 logic into the result register and
//   raises out_valid. Throughput is one word per cycle while the receiver
//   does not stall, as the timer and flag state update once per word.
//   When the receiver stalls, the result register holds and the input
//   register can still take one more word; after that in_stall rises.
//   Synchronous reset empties both registers, clears the timer and flag
//   state, and loads OPTION with all ones and the enables with zero.
`default_nettype none

module timer0_and_interrupt_unit
  import tmr0i_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire in_t                       in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output out_t                           out_data,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  cfg_t cfg;
  logic s1_valid;
  in_t  s1_data;
  logic advance;
  logic step_en;
  out_t res;

  assign cfg_ready = 1'b1;

  tmr0i_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The result register frees up when empty or when its word is taken.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign step_en  = s1_valid && advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= in_data;
    end
  end

  tmr0i_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .cfg     (cfg),
    .item    (s1_data),
    .res     (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

### src/tmr0i_cfg.sv
// Configuration registers (OPTION and interrupt source enables).
// Depends on tmr0i_pkg.
`default_nettype none

module tmr0i_cfg
  import tmr0i_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_valid,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  output cfg_t                           cfg
);

  logic [7:0] option_value;
  logic [2:0] source_enables;

  // Register writes; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      option_value   <= OPTION_RESET;
      source_enables <= ENABLES_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OPTION:  option_value   <= cfg_data;
        CFG_ENABLES: source_enables <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Field decode.
  always_comb begin
    cfg.intedg = option_value[6];
    cfg.t0cs   = option_value[5];
    cfg.t0se   = option_value[4];
    cfg.psa    = option_value[3];
    cfg.ps     = option_value[2:0];
    cfg.t0ie   = source_enables[2];
    cfg.inte   = source_enables[1];
    cfg.rbie   = source_enables[0];
  end

endmodule

`default_nettype wire

### src/tmr0i_core.sv
// Interrupt detection and Timer0 step for one instruction, with the state registers.
// Depends on tmr0i_pkg.
`default_nettype none

module tmr0i_core
  import tmr0i_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic step_en,
  input  wire cfg_t cfg,
  input  wire in_t  item,
  output out_t      res
);

  logic [7:0] timer_count, timer_count_next;
  logic [8:0] prescale_count, prescale_count_next;
  logic [3:0] interrupt_flags, interrupt_flags_next;
  logic       last_rb0, last_rb0_next;
  logic [3:0] last_rb_high, last_rb_high_next;
  logic       last_ra4;

  logic [3:0] flags_w;
  logic [7:0] timer_w;
  logic       rb0;
  logic [3:0] rb_high;
  logic [1:0] cause;
  logic [8:0] count_inc;
  logic [8:0] prescale;

  always_comb begin
    // Instruction writes come first.
    flags_w = item.flag_write_enable  ? item.flag_write_value  : interrupt_flags;
    timer_w = item.timer_write_enable ? item.timer_write_value : timer_count;
    rb0     = item.port_b[0];
    rb_high = item.port_b[7:4];

    // Interrupt sources in priority order, gated by GIE.
    cause = CAUSE_NONE;
    if (flags_w[FLAG_GIE]) begin
      if (cfg.inte && (last_rb0 != rb0) && (rb0 == cfg.intedg)) begin
        cause = CAUSE_RB0;
      end else if (cfg.rbie && (last_rb_high != rb_high)) begin
        cause = CAUSE_RBCHG;
      end else if (cfg.t0ie && flags_w[FLAG_T0IF]) begin
        cause = CAUSE_TMR0;
      end
    end

    interrupt_flags_next = flags_w;
    last_rb0_next        = last_rb0;
    last_rb_high_next    = last_rb_high;
    if (cause != CAUSE_NONE) begin
      interrupt_flags_next[FLAG_GIE] = 1'b0;
      if (cause == CAUSE_RB0) begin
        interrupt_flags_next[FLAG_INTF] = 1'b1;
      end
      if (cause == CAUSE_RBCHG) begin
        interrupt_flags_next[FLAG_RBIF] = 1'b1;
      end
    end else begin
      last_rb0_next     = rb0;
      last_rb_high_next = rb_high;
    end

    // Timer0 clock: instruction cycles, or the selected RA4 edge.
    count_inc = 9'd0;
    if (!cfg.t0cs) begin
      count_inc = {7'd0, item.cycles_passed};
    end else if ((last_ra4 != item.ra4_pin) && (last_ra4 == cfg.t0se)) begin
      count_inc = 9'd1;
    end
    prescale_count_next = prescale_count + count_inc;

    prescale = cfg.psa ? 9'd1 : (9'd2 << cfg.ps);
    timer_count_next = timer_w;
    if (prescale_count_next >= prescale) begin
      if (timer_w == TMR0_MAX) begin
        interrupt_flags_next[FLAG_T0IF] = 1'b1;
      end
      timer_count_next    = timer_w + 8'd1;
      prescale_count_next = 9'd0;
    end

    res.take_interrupt  = (cause != CAUSE_NONE);
    res.interrupt_cause = cause;
    res.return_address  = (cause != CAUSE_NONE) ? item.program_counter : '0;
    res.timer_value     = timer_count_next;
    res.flag_bits       = interrupt_flags_next;
  end

  // State advances once per processed instruction.
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_count     <= 8'd0;
      prescale_count  <= 9'd0;
      interrupt_flags <= 4'd0;
      last_rb0        <= 1'b0;
      last_rb_high    <= 4'd0;
      last_ra4        <= 1'b0;
    end else if (step_en) begin
      timer_count     <= timer_count_next;
      prescale_count  <= prescale_count_next;
      interrupt_flags <= interrupt_flags_next;
      last_rb0        <= last_rb0_next;
      last_rb_high    <= last_rb_high_next;
      last_ra4        <= item.ra4_pin;
    end
  end

endmodule

`default_nettype wire

### src/tmr0i_checker.sv
// Port-level checks for the Timer0 and interrupt unit, bound to the top level.
// Depends on tmr0i_pkg and timer0_and_interrupt_unit.
`default_nettype none

module tmr0i_checker
  import tmr0i_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire out_t out_data
);

  // The result register is empty right after reset.
  a_empty_after_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result word valid right after reset");

  // The take flag agrees with the cause code.
  a_take_matches_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.take_interrupt == (out_data.interrupt_cause != CAUSE_NONE)))
    else $error("take_interrupt disagrees with interrupt_cause");

  // No return address without a taken interrupt.
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.take_interrupt) |-> (out_data.return_address == '0))
    else $error("return address set without an interrupt");

  // A taken interrupt leaves GIE clear.
  a_gie_cleared: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.take_interrupt) |-> !out_data.flag_bits[FLAG_GIE])
    else $error("GIE still set after a taken interrupt");

endmodule

bind timer0_and_interrupt_unit tmr0i_checker u_tmr0i_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire
